// ----- rtl/core/canopen_lss_slave_frame_handler_core_macros.svh -----
// Assertion macros shared by the LSS slave frame handler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CANOPEN_LSS_SLAVE_FRAME_HANDLER_CORE_MACROS_SVH
`define CANOPEN_LSS_SLAVE_FRAME_HANDLER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/lss_fh_pkg.sv -----
// Types and constants for the LSS slave frame handler.
// Used by every module of the block; depends on nothing.
package lss_fh_pkg;

   localparam logic [10:0] LSS_RX_ID    = 11'h7E5;
   localparam logic [3:0]  LSS_FRAME_LEN = 4'd8;

   localparam logic [7:0] CMD_SWITCH_GLOBAL = 8'd4;
   localparam logic [7:0] CMD_ID_VENDOR     = 8'd64;
   localparam logic [7:0] CMD_ID_PRODUCT    = 8'd65;
   localparam logic [7:0] CMD_ID_REVISION   = 8'd66;
   localparam logic [7:0] CMD_ID_SERIAL     = 8'd67;
   localparam logic [7:0] CMD_ID_REPLY      = 8'd68;
   localparam logic [7:0] CMD_CFG_NODE      = 8'd17;
   localparam logic [7:0] CMD_CFG_TIMING    = 8'd19;
   localparam logic [7:0] CMD_ACT_TIMING    = 8'd21;
   localparam logic [7:0] CMD_STORE         = 8'd23;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_VENDOR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRODUCT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVISION = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERIAL   = 2'd3;

   typedef enum logic [2:0] {
      NOTIFY_NONE     = 3'd0,
      NOTIFY_MODE     = 3'd1,
      NOTIFY_NODE_ID  = 3'd2,
      NOTIFY_TIMING   = 3'd3,
      NOTIFY_ACTIVATE = 3'd4,
      NOTIFY_STORE    = 3'd5
   } notify_kind_type;

   typedef struct packed {
      logic [10:0] frame_id;
      logic [3:0]  frame_length;
      logic [7:0]  command_byte;
      logic [31:0] argument_word;
      logic [7:0]  app_error_code;
      logic [7:0]  app_specific_error;
   } req_type;

   typedef struct packed {
      logic        response_valid;
      logic [7:0]  response_command;
      logic [7:0]  response_byte_one;
      logic [7:0]  response_byte_two;
      logic [2:0]  notify_kind;
      logic [15:0] notify_arg;
      logic [7:0]  mode_now;
      logic        accepted;
   } rsp_type;

   typedef struct packed {
      logic [31:0] vendor;
      logic [31:0] product;
      logic [31:0] revision;
      logic [31:0] serial;
   } ident_type;

   typedef struct packed {
      logic       mode_we;
      logic [7:0] mode_next;
   } mode_upd_type;

endpackage

// ----- rtl/core/lss_fh_ident_regs.sv -----
// Identity registers compared by the identify commands.
// Depends on lss_fh_pkg.
module lss_fh_ident_regs
   import lss_fh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output ident_type              ident
);

   ident_type ident_ff, ident_in;

   always_comb begin
      ident_in = ident_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VENDOR:   ident_in.vendor   = csr_wdata;
            CSR_PRODUCT:  ident_in.product  = csr_wdata;
            CSR_REVISION: ident_in.revision = csr_wdata;
            CSR_SERIAL:   ident_in.serial   = csr_wdata;
            default:      ident_in = ident_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff <= '0;
      end else begin
         ident_ff <= ident_in;
      end
   end

   assign ident = ident_ff;

endmodule

// ----- rtl/core/lss_fh_decode.sv -----
// Command decode for one registered frame: builds the result and the mode update.
// Depends on lss_fh_pkg.
module lss_fh_decode
   import lss_fh_pkg::*;
(
   input  req_type      req,
   input  logic [7:0]   mode,
   input  ident_type    ident,
   output rsp_type      rsp,
   output mode_upd_type mode_upd
);

   logic       for_us;
   logic       id_match;
   logic [7:0] toggled;
   logic [7:0] b1;

   assign for_us  = (req.frame_id == LSS_RX_ID) && (req.frame_length == LSS_FRAME_LEN);
   assign toggled = (mode == 8'd0) ? 8'd1 : 8'd0;
   assign b1      = req.argument_word[7:0];

   always_comb begin
      unique case (req.command_byte)
         CMD_ID_VENDOR:   id_match = (req.argument_word == ident.vendor);
         CMD_ID_PRODUCT:  id_match = (req.argument_word == ident.product);
         CMD_ID_REVISION: id_match = (req.argument_word == ident.revision);
         CMD_ID_SERIAL:   id_match = (req.argument_word == ident.serial);
         default:         id_match = 1'b0;
      endcase
   end

   always_comb begin
      rsp                = '0;
      mode_upd.mode_we   = 1'b0;
      mode_upd.mode_next = mode;
      if (for_us) begin
         if (req.command_byte == CMD_SWITCH_GLOBAL) begin
            mode_upd.mode_we   = 1'b1;
            mode_upd.mode_next = b1;
            rsp.notify_kind    = NOTIFY_MODE;
            rsp.notify_arg     = {8'd0, b1};
            rsp.accepted       = 1'b1;
         end else if (id_match) begin
            // Each matching field flips the mode on its own.
            mode_upd.mode_we      = 1'b1;
            mode_upd.mode_next    = toggled;
            rsp.response_valid    = 1'b1;
            rsp.response_command  = CMD_ID_REPLY;
            rsp.response_byte_one = toggled;
            rsp.notify_kind       = NOTIFY_MODE;
            rsp.notify_arg        = {8'd0, toggled};
         end else begin
            case (req.command_byte)
               CMD_CFG_NODE, CMD_CFG_TIMING, CMD_ACT_TIMING, CMD_STORE: begin
                  rsp.response_valid    = 1'b1;
                  rsp.response_command  = req.command_byte;
                  rsp.response_byte_one = req.app_error_code;
                  rsp.response_byte_two = req.app_specific_error;
               end
               default: ;
            endcase
            case (req.command_byte)
               CMD_CFG_NODE: begin
                  rsp.notify_kind = NOTIFY_NODE_ID;
                  rsp.notify_arg  = {8'd0, b1};
               end
               CMD_CFG_TIMING: begin
                  rsp.notify_kind = NOTIFY_TIMING;
                  rsp.notify_arg  = req.argument_word[15:0];
               end
               CMD_ACT_TIMING: begin
                  rsp.notify_kind = NOTIFY_ACTIVATE;
                  rsp.notify_arg  = req.argument_word[15:0];
               end
               CMD_STORE: begin
                  rsp.notify_kind = NOTIFY_STORE;
               end
               default: ;
            endcase
         end
      end
      rsp.mode_now = mode_upd.mode_next;
   end

endmodule

// ----- rtl/core/canopen_lss_slave_frame_handler_core.sv -----
// Top level of the LSS slave frame handler: input register, decode, result register.
// Depends on lss_fh_pkg, lss_fh_ident_regs, lss_fh_decode and the assertion macros.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_data   (received frame)
//   rsp_      out        rsp_valid/rsp_stall   rsp_data   (result of one frame)
//   csr_      in         csr_we                csr_index, csr_wdata
//
// A request is registered in the input stage, decoded and written to the result register
// as that register frees; one request is taken every cycle while the result is not stalled.
// The mode register is updated as a request moves into the result register.
// Synchronous reset clears the identity registers, the mode and both valid flags.
// A stalled result holds the input stage; req_stall rises only when both are full.
`include "canopen_lss_slave_frame_handler_core_macros.svh"

module canopen_lss_slave_frame_handler_core
   import lss_fh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ident_type    ident;
   rsp_type      dec_rsp;
   mode_upd_type mode_upd;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [7:0] mode_ff, mode_in;

   logic s1_moves;
   logic req_take;

   lss_fh_ident_regs u_ident (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ident     (ident)
   );

   lss_fh_decode u_decode (
      .req      (s1_data_ff),
      .mode     (mode_ff),
      .ident    (ident),
      .rsp      (dec_rsp),
      .mode_upd (mode_upd)
   );

   assign s1_moves  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_moves;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_moves);
      s1_data_in   = req_take ? req_data : s1_data_ff;
      rsp_valid_in = s1_moves || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = s1_moves ? dec_rsp : rsp_data_ff;
      mode_in      = (s1_moves && mode_upd.mode_we) ? mode_upd.mode_next : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 8'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LSS_ASSERT_SAME(a_accept_no_reply, clock, reset, rsp_valid && rsp_data.accepted, !rsp_data.response_valid, "mode switch result carries a reply")
   `LSS_ASSERT_SAME(a_reply_notifies, clock, reset, rsp_valid && rsp_data.response_valid, rsp_data.notify_kind != NOTIFY_NONE, "reply without notification")
   `LSS_ASSERT_NEXT(a_mode_hold, clock, reset, !reset && !s1_moves, $stable(mode_ff), "mode changed with no request moving")

endmodule
